// ===== rtl/lis_pkg.sv =====
// Shared types and constants for the longest increasing subsequence block.
// No dependencies; used by the interfaces, the input queue and the search engine.
`default_nettype none

package lis_pkg;

  localparam int VALUE_W = 32;
  localparam int RL_W    = 11;

  // Input queue between the front and the search engine (keep a power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  // Head of the input queue as seen by the search engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

`default_nettype wire

// ===== rtl/lis_if.sv =====
// Valid/ready channel interfaces for the input items and the results.
// Depends on lis_pkg for the field widths.
`default_nettype none

interface lis_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [lis_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface lis_out_if;
  logic                        valid;
  logic                        ready;
  logic [lis_pkg::RL_W-1:0]    run_length;
  logic                        seq_end;
  logic                        overflow;

  modport source (output valid, output run_length, output seq_end, output overflow,
                  input ready);
  modport sink   (input valid, input run_length, input seq_end, input overflow,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/lis_front.sv =====
// Front end: accepts input transactions into a short queue ahead of the search engine.
// Depends on lis_pkg and lis_in_if.
`default_nettype none

module lis_front (
  input  wire logic           clk,
  input  wire logic           rst,
  lis_in_if.sink              items,
  output lis_pkg::head_t      head,
  input  wire logic           pop
);

  lis_pkg::item_t                 slots [lis_pkg::QUEUE_DEPTH];
  logic [lis_pkg::QPTR_W-1:0]     wr_ptr;
  logic [lis_pkg::QPTR_W-1:0]     rd_ptr;
  logic [lis_pkg::QCNT_W-1:0]     fill;
  logic                           push;
  logic                           take;

  assign items.ready = (fill != lis_pkg::QCNT_W'(lis_pkg::QUEUE_DEPTH));
  assign push        = items.valid && items.ready;
  assign take        = pop && (fill != '0);

  assign head.valid  = (fill != '0);
  assign head.item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].value <= items.value;
      slots[wr_ptr].last  <= items.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      priority if (push && !take) begin
        fill <= fill + 1'b1;
      end else if (take && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lis_back.sv =====
// Back end: binary search over the tails memory, tails update and result register.
// Depends on lis_pkg and lis_out_if.
`default_nettype none

module lis_back #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lis_pkg::head_t head,
  output logic                pop,
  lis_out_if.source           results
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]                         state;
  logic signed [lis_pkg::VALUE_W-1:0] tails [MAX_LEN];
  logic signed [lis_pkg::VALUE_W-1:0] rdata;
  logic [IDX_W-1:0]                   rd_addr;

  logic signed [lis_pkg::VALUE_W-1:0] v;
  logic                               is_last;
  logic                               do_append;
  logic [IDX_W-1:0]                   idx;
  logic [IDX_W-1:0]                   lo;
  logic [IDX_W-1:0]                   hi;
  logic [IDX_W-1:0]                   mid;
  logic [CNT_W-1:0]                   tail_count;
  logic                               overflow_seen;
  logic signed [lis_pkg::VALUE_W-1:0] last_tail;

  logic                               out_valid;
  logic [lis_pkg::RL_W-1:0]           out_run_length;
  logic                               out_seq_end;
  logic                               out_overflow;

  // Search step and commit signals
  logic [IDX_W-1:0]                   hi_start;
  logic [IDX_W-1:0]                   lo_next;
  logic [IDX_W-1:0]                   hi_next;
  logic [IDX_W:0]                     sum_next;
  logic                               fire;
  logic                               full;
  logic                               we;
  logic [IDX_W-1:0]                   waddr;
  logic [CNT_W-1:0]                   count_next;
  logic                               ovf_next;

  assign full     = (tail_count == CNT_W'(MAX_LEN));
  assign hi_start = IDX_W'(tail_count - CNT_W'(1));
  assign fire     = (state == S_DONE) && (!out_valid || results.ready);
  assign pop      = (state == S_IDLE) && head.valid;

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (rdata < v) begin
      lo_next = mid + 1'b1;
    end else begin
      hi_next = mid;
    end
    sum_next = {1'b0, lo_next} + {1'b0, hi_next};
  end

  // Read address for the probe that the next cycle compares
  always_comb begin
    rd_addr = mid;
    if (state == S_IDLE) begin
      rd_addr = hi_start >> 1;
    end else if (state == S_SEARCH) begin
      rd_addr = sum_next[IDX_W:1];
    end
  end

  always_comb begin
    we         = 1'b0;
    waddr      = idx;
    count_next = tail_count;
    ovf_next   = overflow_seen;
    if (fire) begin
      if (do_append) begin
        if (full) begin
          ovf_next = 1'b1;
        end else begin
          we         = 1'b1;
          waddr      = tail_count[IDX_W-1:0];
          count_next = tail_count + 1'b1;
        end
      end else begin
        we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata <= tails[rd_addr];
    if (we) tails[waddr] <= v;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      v       <= head.item.value;
      is_last <= head.item.last;
    end
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          do_append <= (tail_count == '0) || (head.item.value > last_tail);
          idx       <= '0;
          lo        <= '0;
          hi        <= hi_start;
          mid       <= hi_start >> 1;
        end
      end
      S_SEARCH: begin
        lo  <= lo_next;
        hi  <= hi_next;
        mid <= sum_next[IDX_W:1];
        idx <= lo_next;
      end
      default: begin
      end
    endcase
    // Keep the copy of the top tail in step with the memory
    if (we && (do_append || (idx == hi_start))) last_tail <= v;
    if (fire) begin
      out_run_length <= lis_pkg::RL_W'(count_next);
      out_seq_end    <= is_last;
      out_overflow   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tail_count    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if ((tail_count == '0) || (head.item.value > last_tail) || (hi_start == '0)) begin
              state <= S_DONE;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (lo_next == hi_next) state <= S_DONE;
        end
        S_DONE: begin
          if (fire) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (fire) begin
        out_valid <= 1'b1;
        // Close the sequence after its result is formed
        if (is_last) begin
          tail_count    <= '0;
          overflow_seen <= 1'b0;
        end else begin
          tail_count    <= count_next;
          overflow_seen <= ovf_next;
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid      = out_valid;
  assign results.run_length = out_run_length;
  assign results.seq_end    = out_seq_end;
  assign results.overflow   = out_overflow;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tail_count <= CNT_W'(MAX_LEN))
    else $error("tail count beyond table size");

  a_search_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo < hi) && (mid >= lo) && (mid < hi))
    else $error("search window empty or probe outside it");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> full)
    else $error("overflow flagged with room left in the table");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented without a commit");
`endif

endmodule

`default_nettype wire

// ===== rtl/longest_increasing_subsequence.sv =====
// Top level of the longest strictly increasing subsequence block.
// Depends on lis_pkg, lis_if, lis_front and lis_back.
`default_nettype none

// Takes one signed 32-bit value per transaction and returns one result per value:
// the length of the longest strictly increasing subsequence seen so far in the
// current sequence, a copy of the last mark, and a sticky overflow flag that is set
// when an append is dropped because the MAX_LEN-entry tails table is full. An item
// with last set closes the sequence; the next item starts a fresh one. A value that
// extends the longest run (or starts a sequence, or meets a single stored tail) goes
// straight to the commit state in the search engine; any other value runs a binary
// search over the tails memory at one probe per cycle. The tails memory has a single
// read port. A two-entry input queue and the result register keep both channels
// moving while the engine works. No clearing pass is needed after reset.
module longest_increasing_subsequence #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lis_in_if.sink     items,
  lis_out_if.source  results
);

  lis_pkg::head_t head;
  logic           pop;

  lis_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .head  (head),
    .pop   (pop)
  );

  lis_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

`default_nettype wire

// ===== dv/lis_checker.sv =====
// Scoreboard for the longest increasing subsequence block: tracks the tails table
// from accepted input transactions and checks every result transaction against it.
// Depends on lis_pkg and the lis_in_if / lis_out_if interfaces.
`default_nettype none

module lis_checker #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  lis_in_if         items,
  lis_out_if        results,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lis_pkg::RL_W-1:0] run_length;
    logic                     seq_end;
    logic                     overflow;
  } lis_result_t;

  // Shadow of the tails table; entries at or above tail_depth are never read.
  logic signed [lis_pkg::VALUE_W-1:0] tails_mem [MAX_LEN];
  int unsigned                        tail_depth;
  logic                               append_dropped;
  lis_result_t                        length_q [$];
  int                                 errors;

  // Apply one value to the shadow table and return the result it should produce.
  function automatic lis_result_t apply_value(logic signed [lis_pkg::VALUE_W-1:0] v,
                                              logic fin);
    lis_result_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (tail_depth == 0 || v > tails_mem[tail_depth-1]) begin
      if (tail_depth < MAX_LEN) begin
        tails_mem[tail_depth] = v;
        tail_depth++;
      end else begin
        append_dropped = 1'b1;
      end
    end else begin
      // lower bound: first tail not less than v
      lo = 0;
      hi = tail_depth;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (tails_mem[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      tails_mem[lo] = v;
    end
    r.run_length = lis_pkg::RL_W'(tail_depth);
    r.seq_end    = fin;
    r.overflow   = append_dropped;
    if (fin) begin
      tail_depth     = 0;
      append_dropped = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lis_result_t want;
    lis_result_t seen;
    if (rst) begin
      tail_depth     = 0;
      append_dropped = 1'b0;
      length_q.delete();
    end else begin
      // results first: a transaction accepted on this edge cannot answer itself
      if (results.valid && results.ready) begin
        seen.run_length = results.run_length;
        seen.seq_end    = results.seq_end;
        seen.overflow   = results.overflow;
        if (length_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing expected: %0d %0b %0b",
                     $realtime, seen.run_length, seen.seq_end, seen.overflow);
        end else begin
          want = length_q.pop_front();
          if (seen.run_length !== want.run_length || seen.seq_end !== want.seq_end ||
              seen.overflow !== want.overflow) begin
            errors++;
            if (errors <= 10)
              $display("%0t: expected %0d %0b %0b, got %0d %0b %0b",
                       $realtime, want.run_length, want.seq_end, want.overflow,
                       seen.run_length, seen.seq_end, seen.overflow);
          end
        end
      end
      if (items.valid && items.ready)
        length_q.insert(length_q.size(), apply_value(items.value, items.last));
    end
    mismatches  <= errors;
    outstanding <= length_q.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Top of the testbench: clock, reset, directed and random value sequences, result
// back-pressure and the final verdict. Depends on lis_pkg, the lis interfaces,
// lis_checker and the longest_increasing_subsequence block.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN     = 1024;
  localparam int CYCLE_LIMIT = 300_000;
  localparam int RANDOM_HEAD = 480;
  localparam int LONG_RUN    = 1200;
  localparam int CALM_FROM   = 400;
  localparam int CALM_TO     = 750;

  localparam logic signed [lis_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [lis_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  typedef enum int {MIX_WIDE, MIX_NARROW, MIX_RISING} mix_e;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  int   sent_cnt;
  int   cycles;
  int   mism;
  int   outst;

  lis_in_if  items_ch ();
  lis_out_if results_ch ();

  longest_increasing_subsequence #(.MAX_LEN(MAX_LEN)) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  lis_checker #(.MAX_LEN(MAX_LEN)) chk (
    .clk         (clk),
    .rst         (rst),
    .items       (items_ch),
    .results     (results_ch),
    .mismatches  (mism),
    .outstanding (outst)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    results_ch.ready <= calm || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offer one transaction, with random idle cycles ahead of it outside the calm window.
  task automatic send_value(logic signed [lis_pkg::VALUE_W-1:0] v, logic fin);
    while (!calm && $urandom_range(99) < 34) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.value <= v;
    items_ch.last  <= fin;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    sent_cnt <= sent_cnt + 1;
    calm     <= (sent_cnt + 1 >= CALM_FROM) && (sent_cnt + 1 < CALM_TO);
  endtask

  // One closed sequence; rising mode mostly appends, with some replacements at or below the top.
  task automatic run_sequence(int len, mix_e mix);
    logic signed [lis_pkg::VALUE_W-1:0] v;
    logic signed [lis_pkg::VALUE_W-1:0] prev;
    prev = VALUE_MIN + 32'(1 << 21) + $urandom_range(1000);
    for (int i = 0; i < len; i++) begin
      unique case (mix)
        MIX_WIDE: begin
          v = $urandom;
        end
        MIX_NARROW: begin
          v = $urandom_range(16) - 8;
        end
        default: begin
          if ($urandom_range(99) < 95) begin
            v    = prev + $urandom_range(1 << 20, 1);
            prev = v;
          end else begin
            v = prev - $urandom_range(1 << 20, 0);
          end
        end
      endcase
      send_value(v, i == len - 1);
    end
  endtask

  initial begin
    int head_cnt;
    int len;
    rst            <= 1'b1;
    calm           <= 1'b0;
    sent_cnt       <= 0;
    items_ch.valid <= 1'b0;
    items_ch.value <= '0;
    items_ch.last  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // start of sequence, equal values, field extremes
    send_value(0, 1'b0);
    send_value(0, 1'b0);
    send_value(VALUE_MAX, 1'b0);
    send_value(VALUE_MIN, 1'b0);
    send_value(-1, 1'b0);
    send_value(5, 1'b1);
    // single-item sequence
    send_value(VALUE_MIN, 1'b1);
    // strictly decreasing
    send_value(3, 1'b0);
    send_value(2, 1'b0);
    send_value(1, 1'b1);
    // mixed with a repeat in the middle
    send_value(1, 1'b0);
    send_value(2, 1'b0);
    send_value(2, 1'b0);
    send_value(3, 1'b0);
    send_value(1, 1'b0);
    send_value(4, 1'b1);
    send_value(VALUE_MAX, 1'b0);
    send_value(VALUE_MAX, 1'b0);
    send_value(VALUE_MIN, 1'b1);

    head_cnt = 0;
    while (head_cnt < RANDOM_HEAD) begin
      len = $urandom_range(40, 1);
      run_sequence(len, mix_e'($urandom_range(2)));
      head_cnt += len;
    end

    // long rising sequence: fills the table and runs into overflow
    run_sequence(LONG_RUN, MIX_RISING);

    // fresh sequences after the overflow
    repeat (3) run_sequence($urandom_range(20, 1), MIX_WIDE);
    run_sequence($urandom_range(30, 10), MIX_RISING);

    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (outst != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mism == 0 && outst == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/lis_pkg.sv
rtl/lis_if.sv
rtl/lis_front.sv
rtl/lis_back.sv
rtl/longest_increasing_subsequence.sv
dv/lis_checker.sv
dv/tb_top.sv
